// ----- rtl/dq_pkg.sv -----
// Package for the double-ended queue core.
// Holds operation and status codes and the structs passed between submodules.
// No dependencies.
package dq_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 9;
  localparam int unsigned StatusW = 2;

  localparam logic [FuncW-1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [FuncW-1:0] FUNC_PUSH_BACK  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_POP_FRONT  = 2'd2;
  localparam logic [FuncW-1:0] FUNC_POP_BACK   = 2'd3;

  localparam logic [StatusW-1:0] STATUS_DONE       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_PUSH_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_POP_EMPTY  = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } dq_mem_ctl_t;

  typedef struct packed {
    logic               valid;
    logic               pop_ok;
    logic [CountW-1:0]  count;
    logic               empty;
    logic [StatusW-1:0] status;
  } dq_result_t;

endpackage

// ----- rtl/dq_store.sv -----
// Entry storage of the double-ended queue: one synchronous RAM with one
// write or read per cycle and a registered read port.
// Depends on dq_pkg.
module dq_store
  import dq_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  dq_mem_ctl_t       ctl_i,
  input  logic [AddrW-1:0]  addr_i,
  input  logic [WordW-1:0]  wdata_i,
  output logic [WordW-1:0]  rdata_o
);

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dq_ctrl.sv -----
// Index and count control of the double-ended queue. Turns each operation that
// is not rejected into one RAM access and registers the result flags for the next cycle.
// Depends on dq_pkg.
module dq_ctrl
  import dq_pkg::*;
#(
  parameter int unsigned Depth  = 256,
  parameter int unsigned AddrW  = $clog2(Depth),
  parameter int unsigned CntW   = $clog2(Depth + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [FuncW-1:0]   func_i,
  input  logic [WordW-1:0]   push_value_i,
  output dq_mem_ctl_t        mem_ctl_o,
  output logic [AddrW-1:0]   mem_addr_o,
  output logic [WordW-1:0]   mem_wdata_o,
  output dq_result_t         result_o
);

  localparam logic [AddrW-1:0] IdxLast = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  CntFull = CntW'(Depth);

  logic [AddrW-1:0] front_q, front_d;
  logic [AddrW-1:0] back_q, back_d;
  logic [CntW-1:0]  count_q, count_d;
  dq_result_t       result_q, result_d;

  logic [AddrW-1:0] front_prev, front_next, back_prev, back_next;
  logic             is_push, full, empty;

  assign front_prev = (front_q == '0) ? IdxLast : front_q - AddrW'(1);
  assign front_next = (front_q == IdxLast) ? '0 : front_q + AddrW'(1);
  assign back_prev  = (back_q == '0) ? IdxLast : back_q - AddrW'(1);
  assign back_next  = (back_q == IdxLast) ? '0 : back_q + AddrW'(1);

  assign is_push = (func_i == FUNC_PUSH_FRONT) || (func_i == FUNC_PUSH_BACK);
  assign full    = (count_q == CntFull);
  assign empty   = (count_q == '0);

  always_comb begin
    front_d          = front_q;
    back_d           = back_q;
    count_d          = count_q;
    mem_ctl_o        = '0;
    mem_addr_o       = front_q;
    result_d         = '0;
    result_d.valid   = accept_i;
    result_d.status  = STATUS_DONE;
    if (accept_i) begin
      if (is_push && full) begin
        result_d.status = STATUS_PUSH_FULL;
      end else if (!is_push && empty) begin
        result_d.status = STATUS_POP_EMPTY;
      end else begin
        case (func_i)
          FUNC_PUSH_FRONT: begin
            front_d         = front_prev;
            mem_addr_o      = front_prev;
            mem_ctl_o.wr_en = 1'b1;
            count_d         = count_q + CntW'(1);
          end
          FUNC_PUSH_BACK: begin
            back_d          = back_next;
            mem_addr_o      = back_next;
            mem_ctl_o.wr_en = 1'b1;
            count_d         = count_q + CntW'(1);
          end
          FUNC_POP_FRONT: begin
            mem_addr_o      = front_q;
            front_d         = front_next;
            mem_ctl_o.rd_en = 1'b1;
            count_d         = count_q - CntW'(1);
          end
          default: begin
            mem_addr_o      = back_q;
            back_d          = back_prev;
            mem_ctl_o.rd_en = 1'b1;
            count_d         = count_q - CntW'(1);
          end
        endcase
      end
    end
    result_d.pop_ok = mem_ctl_o.rd_en;
    result_d.count  = CountW'(count_d);
    result_d.empty  = (count_d == '0);
  end

  assign mem_wdata_o = push_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      back_q   <= IdxLast;
      count_q  <= '0;
      result_q <= '0;
    end else begin
      front_q  <= front_d;
      back_q   <= back_d;
      count_q  <= count_d;
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ----- rtl/double_ended_queue_core.sv -----
// Top level of the double-ended queue core: control plus entry RAM.
// Depends on dq_pkg, dq_ctrl and dq_store.
//
//   channel   direction  handshake            payload
//   command   in         start_i, busy_o      func_i, push_value_i
//   result    out        done_o (one cycle)   pop_value_o, count_after_o,
//                                             is_empty_o, status_o
//
// One command is taken per cycle while busy_o is low; its result appears on done_o in the
// next cycle, and on a pop the word comes from the registered read port of the entry RAM.
// A push written in one cycle is visible to a pop issued in the next one.
// After reset release busy_o stays high for one cycle; the RAM needs no
// clearing pass since only written entries are ever read.
// The receiver cannot stall, so results never wait.
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [FuncW-1:0]    func_i,
  input  logic signed [WordW-1:0] push_value_i,
  output logic                done_o,
  output logic signed [WordW-1:0] pop_value_o,
  output logic [CountW-1:0]   count_after_o,
  output logic                is_empty_o,
  output logic [StatusW-1:0]  status_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic             busy_q;
  logic             accept;
  dq_mem_ctl_t      mem_ctl;
  logic [AddrW-1:0] mem_addr;
  logic [WordW-1:0] mem_wdata;
  logic [WordW-1:0] mem_rdata;
  dq_result_t       result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  dq_ctrl #(
    .Depth (CAPACITY),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (func_i),
    .push_value_i (push_value_i),
    .mem_ctl_o    (mem_ctl),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .result_o     (result)
  );

  dq_store #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign done_o        = result.valid;
  assign pop_value_o   = result.pop_ok ? mem_rdata : '0;
  assign count_after_o = result.count;
  assign is_empty_o    = result.empty;
  assign status_o      = result.status;

`ifndef SYNTHESIS
  // Every accepted transaction yields its result in the following cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted transaction produced no result");

  // No result without a transaction accepted in the previous cycle.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result strobe without accepted transaction");

  // A rejected operation never reports a popped word.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_DONE) |-> (pop_value_o == '0))
    else $error("rejected operation returned a nonzero word");

  // The empty flag agrees with the reported count while the count fits.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && CAPACITY < 512) |-> (is_empty_o == (count_after_o == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for double_ended_queue_core: drives push and pop commands,
// predicts every reply from a shadow circular buffer and checks each reply field by field.
// Depends on dq_pkg and the double_ended_queue_core RTL.
`timescale 1ns / 1ps

module testbench
  import dq_pkg::*;
();

  localparam int unsigned Depth      = 256;
  localparam int unsigned IdxW       = $clog2(Depth);
  localparam int unsigned NumRandom  = 1400;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 8;

  typedef struct {
    logic [FuncW-1:0]        func;
    logic signed [WordW-1:0] value;
  } deque_cmd_t;

  typedef struct {
    logic signed [WordW-1:0] pop_value;
    logic [CountW-1:0]       count;
    logic                    empty;
    logic [StatusW-1:0]      status;
  } deque_reply_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    start_i      = 1'b0;
  logic [FuncW-1:0]        func_i       = FUNC_PUSH_FRONT;
  logic signed [WordW-1:0] push_value_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic signed [WordW-1:0] pop_value_o;
  logic [CountW-1:0]       count_after_o;
  logic                    is_empty_o;
  logic [StatusW-1:0]      status_o;

  // Shadow copy of the queue contents and pointers.
  logic [WordW-1:0] shadow_mem [Depth];
  int unsigned      shadow_front = 0;
  int unsigned      shadow_back  = Depth - 1;
  int unsigned      shadow_count = 0;

  deque_cmd_t   cmd_backlog[$];
  deque_reply_t pending_replies[$];
  int unsigned  plan_count   = 0;
  int unsigned  error_count  = 0;
  int unsigned  cycle_count  = 0;
  int unsigned  gap_left     = 0;
  int unsigned  calm_run     = 0;

  double_ended_queue_core #(
    .CAPACITY(Depth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .push_value_i  (push_value_i),
    .done_o        (done_o),
    .pop_value_o   (pop_value_o),
    .count_after_o (count_after_o),
    .is_empty_o    (is_empty_o),
    .status_o      (status_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Applies one command to the shadow queue and records the reply it must produce.
  task automatic apply_deque_op(input logic [FuncW-1:0] op, input logic [WordW-1:0] word);
    deque_reply_t r;
    r.pop_value = '0;
    r.status    = STATUS_DONE;
    if (op == FUNC_PUSH_FRONT || op == FUNC_PUSH_BACK) begin
      if (shadow_count >= Depth) begin
        r.status = STATUS_PUSH_FULL;
      end else if (op == FUNC_PUSH_FRONT) begin
        shadow_front = (shadow_front == 0) ? Depth - 1 : shadow_front - 1;
        shadow_mem[IdxW'(shadow_front)] = word;
        shadow_count++;
      end else begin
        shadow_back = (shadow_back + 1 >= Depth) ? 0 : shadow_back + 1;
        shadow_mem[IdxW'(shadow_back)] = word;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STATUS_POP_EMPTY;
      end else if (op == FUNC_POP_FRONT) begin
        r.pop_value  = shadow_mem[IdxW'(shadow_front)];
        shadow_front = (shadow_front + 1 >= Depth) ? 0 : shadow_front + 1;
        shadow_count--;
      end else begin
        r.pop_value = shadow_mem[IdxW'(shadow_back)];
        shadow_back = (shadow_back == 0) ? Depth - 1 : shadow_back - 1;
        shadow_count--;
      end
    end
    r.count = shadow_count[CountW-1:0];
    r.empty = (shadow_count == 0);
    pending_replies.push_back(r);
  endtask

  // Adds a command to the backlog while tracking the fill level it will leave.
  task automatic queue_cmd(input logic [FuncW-1:0] op, input logic [WordW-1:0] word);
    deque_cmd_t c;
    c.func  = op;
    c.value = word;
    cmd_backlog.push_back(c);
    if (op == FUNC_PUSH_FRONT || op == FUNC_PUSH_BACK) begin
      if (plan_count < Depth) plan_count++;
    end else if (plan_count > 0) begin
      plan_count--;
    end
  endtask

  function automatic logic [WordW-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly back-to-back commands, some short gaps, a few long ones, and calm stretches
  // where no gap is inserted at all.
  function automatic int unsigned next_gap();
    int unsigned pick;
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      calm_run = $urandom_range(30, 120);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Command driver: holds start_i until the transaction is accepted, then loads the next one.
  always @(posedge clk_i) begin : drive_proc
    logic       accepted;
    logic       next_start;
    deque_cmd_t c;
    if (rst_ni) begin
      accepted   = start_i && !busy_o;
      next_start = start_i && !accepted;
      if (accepted) apply_deque_op(func_i, push_value_i);
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          c = cmd_backlog.pop_front();
          func_i       <= c.func;
          push_value_i <= c.value;
          next_start   = 1'b1;
          gap_left     = next_gap();
        end
      end
      start_i <= next_start;
    end
  end

  // Reply monitor: every done_o cycle is one transaction to compare with the oldest prediction.
  always @(posedge clk_i) begin : check_proc
    deque_reply_t want;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with nothing outstanding", pop_value_o, '0);
      end else begin
        want = pending_replies.pop_front();
        if (pop_value_o !== want.pop_value)
          report_mismatch("pop_value", pop_value_o, want.pop_value);
        if (count_after_o !== want.count)
          report_mismatch("count_after", WordW'(count_after_o), WordW'(want.count));
        if (is_empty_o !== want.empty)
          report_mismatch("is_empty", WordW'(is_empty_o), WordW'(want.empty));
        if (status_o !== want.status)
          report_mismatch("status", WordW'(status_o), WordW'(want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[%0t] timeout with %0d commands and %0d replies outstanding", $time,
               cmd_backlog.size(), pending_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int unsigned mode;
    int unsigned run_len;
    int unsigned round;
    int unsigned target;
    logic [FuncW-1:0] op;

    // Pops on an empty queue, extreme words at both ends, and the front index
    // wrapping below zero on the very first push at the front.
    queue_cmd(FUNC_POP_FRONT, 32'h1234_5678);
    queue_cmd(FUNC_POP_BACK, 32'hffff_ffff);
    queue_cmd(FUNC_PUSH_FRONT, 32'h8000_0000);
    queue_cmd(FUNC_PUSH_BACK, 32'h7fff_ffff);
    queue_cmd(FUNC_PUSH_FRONT, 32'hffff_ffff);
    queue_cmd(FUNC_PUSH_BACK, 32'h0000_0000);
    queue_cmd(FUNC_POP_FRONT, 32'h0);
    queue_cmd(FUNC_POP_BACK, 32'h0);
    queue_cmd(FUNC_POP_BACK, 32'h0);
    queue_cmd(FUNC_POP_FRONT, 32'h0);
    queue_cmd(FUNC_POP_BACK, 32'h0);
    queue_cmd(FUNC_PUSH_BACK, 32'h5555_5555);
    queue_cmd(FUNC_POP_BACK, 32'haaaa_aaaa);
    queue_cmd(FUNC_PUSH_FRONT, 32'haaaa_aaaa);
    queue_cmd(FUNC_POP_FRONT, 32'h5555_5555);
    queue_cmd(FUNC_PUSH_FRONT, 32'h0000_0001);
    queue_cmd(FUNC_POP_BACK, 32'h0);
    queue_cmd(FUNC_POP_FRONT, 32'h0);

    target = cmd_backlog.size() + NumRandom;
    round  = 0;
    while (cmd_backlog.size() < target) begin
      // The first two rounds always fill to full and drain to empty.
      if (round == 0) mode = 5;
      else if (round == 1) mode = 7;
      else mode = $urandom_range(0, 9);
      round++;
      if (mode < 5) begin
        run_len = $urandom_range(20, 80);
        repeat (run_len)
          queue_cmd(FuncW'($urandom_range(FUNC_PUSH_FRONT, FUNC_POP_BACK)), rand_word());
      end else if (mode < 7) begin
        while (plan_count < Depth) begin
          op = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
          queue_cmd(op, rand_word());
        end
        // A few pushes that the full queue must reject.
        repeat ($urandom_range(1, 3))
          queue_cmd(FuncW'($urandom_range(FUNC_PUSH_FRONT, FUNC_PUSH_BACK)), rand_word());
      end else if (mode < 9) begin
        while (plan_count > 0) begin
          op = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
          queue_cmd(op, rand_word());
        end
        repeat ($urandom_range(1, 3))
          queue_cmd(FuncW'($urandom_range(FUNC_POP_FRONT, FUNC_POP_BACK)), rand_word());
      end else begin
        repeat (10)
          queue_cmd(FuncW'($urandom_range(FUNC_PUSH_FRONT, FUNC_POP_BACK)), $urandom);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() > 0 || start_i) @(posedge clk_i);
    while (pending_replies.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dq_pkg.sv
rtl/dq_store.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue_core.sv
tb/sv/testbench.sv
